[rtl/matrix_rotate_flip_engine_macros.svh]
// assertion macros shared by the matrix rotate and flip engine
`ifndef MATRIX_ROTATE_FLIP_ENGINE_MACROS_SVH
`define MATRIX_ROTATE_FLIP_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MRFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MRFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mrf_pkg.sv]
// shared types and constants of the matrix rotate and flip engine
`timescale 1ns / 1ps
package mrf_pkg;

  // input action codes, carried in s_axis_tuser
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_APPLY = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int ACTION_W   = 2;
  localparam int ELEMENT_W  = 32;
  localparam int VALUE_W    = 32;
  localparam int OUT_DIM_W  = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int EXT_W      = 64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic do_load;
    logic do_push;
    logic apply_start;
    logic op_step;
    logic div_step;
    logic out_apply;
    logic out_read;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic ops_pending;
    logic ops_last;
    logic div_done;
    logic read_avail;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/matrix_rotate_flip_engine.sv]
// top level of the matrix rotate and flip engine
`timescale 1ns / 1ps
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: element, op_is_flip
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: value, out_rows, out_cols; tlast
// cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// load and push transactions are taken directly from idle; a read first passes the registered store read
// apply is accepted, then reads (registered op stack read) and composes each stacked operation,
// takes a divide step per full row already loaded in the new layout plus a step that rebuilds
// the load position, and then issues its result
// reset is synchronous and active high; the element store needs no clearing pass
// a finished result waits in the output register while the next transaction is taken;
// a result-producing transaction stalls only while that register is still full
module matrix_rotate_flip_engine #(
  parameter int MAX_DIM    = 8,
  parameter int MAX_OPS    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: element[31:0], op_is_flip[32], zero fill [39:33]
  input  logic [mrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: action[1:0]
  input  logic [mrf_pkg::ACTION_W-1:0]       s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: value[31:0], out_rows[35:32], out_cols[39:36]
  output logic [mrf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  // configuration writes: 0 row_count, 1 col_count
  input  logic                               cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mrf_pkg::*;

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic [VALUE_W-1:0]       out_value;
  logic [OUT_DIM_W-1:0]     out_rows;
  logic [OUT_DIM_W-1:0]     out_cols;

  // sequencing of load, push, apply and read transactions
  mrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .action   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, op stack, remap registers and output register
  mrf_datapath #(
    .MAX_DIM    (MAX_DIM),
    .MAX_OPS    (MAX_OPS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .element    (s_axis_tdata[ELEMENT_W-1:0]),
    .op_is_flip (s_axis_tdata[ELEMENT_W]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (out_value),
    .out_rows   (out_rows),
    .out_cols   (out_cols),
    .out_last   (m_axis_tlast)
  );

  // result fields packed from the lowest bit up
  assign m_axis_tdata = {out_cols, out_rows, out_value};

endmodule

[rtl/mrf_ctrl.sv]
// controller state machine of the matrix rotate and flip engine
`timescale 1ns / 1ps
module mrf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             action,
  output logic                   in_ready,
  input  mrf_pkg::dp_status_t    status,
  output mrf_pkg::ctrl_cmd_t     cmd
);
  import mrf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_AP_RD  = 3'd1;
  localparam logic [2:0] ST_AP_OP  = 3'd2;
  localparam logic [2:0] ST_AP_DIV = 3'd3;
  localparam logic [2:0] ST_AP_OUT = 3'd4;
  localparam logic [2:0] ST_RD_OUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_LOAD: cmd.do_load = 1'b1;
            ACT_PUSH: cmd.do_push = 1'b1;
            ACT_APPLY: begin
              cmd.apply_start = 1'b1;
              state_next = status.ops_pending ? ST_AP_RD : ST_AP_DIV;
            end
            ACT_READ: begin
              if (status.read_avail) state_next = ST_RD_OUT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_AP_RD: state_next = ST_AP_OP;
      ST_AP_OP: begin
        cmd.op_step = 1'b1;
        state_next  = status.ops_last ? ST_AP_DIV : ST_AP_RD;
      end
      ST_AP_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_AP_OUT;
      end
      ST_AP_OUT: begin
        if (status.out_free) begin
          cmd.out_apply = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_RD_OUT: begin
        if (status.out_free) begin
          cmd.out_read = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/mrf_datapath.sv]
// datapath of the matrix rotate and flip engine: store, op stack, address remap
`timescale 1ns / 1ps
module mrf_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int MAX_OPS    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mrf_pkg::ELEMENT_W-1:0]     element,
  input  logic                              op_is_flip,
  input  mrf_pkg::ctrl_cmd_t                cmd,
  output mrf_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrf_pkg::VALUE_W-1:0]       out_value,
  output logic [mrf_pkg::OUT_DIM_W-1:0]     out_rows,
  output logic [mrf_pkg::OUT_DIM_W-1:0]     out_cols,
  output logic                              out_last
);
  import mrf_pkg::*;

  `include "matrix_rotate_flip_engine_macros.svh"

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int PROD_W  = 2 * DIM_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int OPS_AW  = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int OPC_W   = $clog2(MAX_OPS + 1);

  // dimensions and orientation of the current view
  logic [DIM_W-1:0] rows_cfg;
  logic [DIM_W-1:0] cols_cfg;
  logic             swp;
  logic             flip_r;
  logic             flip_c;

  logic [CNT_W-1:0] load_count;
  logic [DIM_W-1:0] li;
  logic [POS_W-1:0] lk;
  logic [CNT_W-1:0] read_index;
  logic [DIM_W-1:0] ri;
  logic [POS_W-1:0] rk;
  logic [CNT_W-1:0] rem;
  logic [OPC_W-1:0] op_count;

  logic [DATA_WIDTH-1:0] store_mem [CELLS];
  logic [DATA_WIDTH-1:0] store_q;
  logic                  stack_mem [MAX_OPS];
  logic                  stack_q;

  logic [DIM_W-1:0]  cur_rows;
  logic [DIM_W-1:0]  cur_cols;
  logic [PROD_W-1:0] total_full;
  logic [CNT_W-1:0]  total;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [OPC_W-1:0]  op_top;
  logic              load_ok;
  logic              push_ok;
  logic [DIM_W-1:0]  cfg_dim;
  logic [EXT_W-1:0]  elem_ext;
  logic [EXT_W-1:0]  rd_ext;
  logic [7:0]        rows_ext;
  logic [7:0]        cols_ext;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [7:0] v8;
    v8 = 8'(v);
    if (v8 == 8'd0) return DIM_W'(1);
    if (v8 > 8'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v8[DIM_W-1:0];
  endfunction

  // logical position of the current view to physical store address
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [POS_W-1:0] i,
                                                  input logic [POS_W-1:0] k);
    logic [POS_W-1:0]  a;
    logic [POS_W-1:0]  b;
    logic [DIM_W-1:0]  pr;
    logic [DIM_W-1:0]  pc;
    logic [PROD_W-1:0] prod;
    a    = swp ? k : i;
    b    = swp ? i : k;
    pr   = flip_r ? (rows_cfg - DIM_W'(1) - DIM_W'(a)) : DIM_W'(a);
    pc   = flip_c ? (cols_cfg - DIM_W'(1) - DIM_W'(b)) : DIM_W'(b);
    prod = PROD_W'(pr) * PROD_W'(cols_cfg) + PROD_W'(pc);
    return prod[ADDR_W-1:0];
  endfunction

  assign cur_rows   = swp ? cols_cfg : rows_cfg;
  assign cur_cols   = swp ? rows_cfg : cols_cfg;
  assign total_full = PROD_W'(rows_cfg) * PROD_W'(cols_cfg);
  assign total      = total_full[CNT_W-1:0];
  assign op_top     = op_count - OPC_W'(1);
  assign load_ok    = cmd.do_load && (load_count < total);
  assign push_ok    = cmd.do_push && (op_count < OPC_W'(MAX_OPS));
  assign cfg_dim    = clamp_dim(cfg_data);
  assign elem_ext   = EXT_W'(element);
  assign rd_ext     = EXT_W'(store_q);
  assign rows_ext   = 8'(cur_rows);
  assign cols_ext   = 8'(cur_cols);

  // store addresses of the load and read positions under the current view
  always_comb begin
    wr_addr = phys_addr(li[POS_W-1:0], lk);
    rd_addr = phys_addr(ri[POS_W-1:0], rk);
  end

  assign status.ops_pending = (op_count != '0);
  assign status.ops_last    = (op_count == OPC_W'(1));
  assign status.div_done    = (rem < CNT_W'(cur_cols));
  assign status.read_avail  = (read_index < total);
  assign status.out_free    = !out_valid || out_ready;

  // element store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (load_ok) store_mem[wr_addr] <= elem_ext[DATA_WIDTH-1:0];
    store_q <= store_mem[rd_addr];
  end

  // op stack, read at the top entry
  always_ff @(posedge clk) begin
    if (push_ok) stack_mem[op_count[OPS_AW-1:0]] <= op_is_flip;
    stack_q <= stack_mem[op_top[OPS_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg   <= DIM_W'(1);
      cols_cfg   <= DIM_W'(1);
      swp        <= 1'b0;
      flip_r     <= 1'b0;
      flip_c     <= 1'b0;
      load_count <= '0;
      li         <= '0;
      lk         <= '0;
      read_index <= '0;
      ri         <= '0;
      rk         <= '0;
      rem        <= '0;
      op_count   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROW_COUNT) rows_cfg <= cfg_dim;
      if (cfg_index == CFG_COL_COUNT) cols_cfg <= cfg_dim;
      swp        <= 1'b0;
      flip_r     <= 1'b0;
      flip_c     <= 1'b0;
      load_count <= '0;
      li         <= '0;
      lk         <= '0;
      read_index <= '0;
      ri         <= '0;
      rk         <= '0;
      op_count   <= '0;
    end else begin
      if (load_ok) begin
        load_count <= load_count + CNT_W'(1);
        if (DIM_W'(lk) == cur_cols - DIM_W'(1)) begin
          lk <= '0;
          li <= li + DIM_W'(1);
        end else begin
          lk <= lk + POS_W'(1);
        end
      end
      if (push_ok) op_count <= op_count + OPC_W'(1);
      if (cmd.apply_start) begin
        rem        <= load_count;
        li         <= '0;
        read_index <= '0;
        ri         <= '0;
        rk         <= '0;
      end
      // compose one stacked operation into the remap
      if (cmd.op_step) begin
        op_count <= op_top;
        if (stack_q) begin
          if (swp) flip_c <= ~flip_c;
          else flip_r <= ~flip_r;
        end else begin
          if (swp) flip_r <= ~flip_r;
          else flip_c <= ~flip_c;
          swp <= ~swp;
        end
      end
      // recover the load row and column under the new column count
      if (cmd.div_step) begin
        if (status.div_done) begin
          lk <= rem[POS_W-1:0];
        end else begin
          rem <= rem - CNT_W'(cur_cols);
          li  <= li + DIM_W'(1);
        end
      end
      if (cmd.out_read) begin
        read_index <= read_index + CNT_W'(1);
        if (DIM_W'(rk) == cur_cols - DIM_W'(1)) begin
          rk <= '0;
          ri <= ri + DIM_W'(1);
        end else begin
          rk <= rk + POS_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_apply || cmd.out_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_apply) begin
      out_value <= '0;
      out_rows  <= rows_ext[OUT_DIM_W-1:0];
      out_cols  <= cols_ext[OUT_DIM_W-1:0];
      out_last  <= 1'b0;
    end else if (cmd.out_read) begin
      out_value <= rd_ext[VALUE_W-1:0];
      out_rows  <= rows_ext[OUT_DIM_W-1:0];
      out_cols  <= cols_ext[OUT_DIM_W-1:0];
      out_last  <= (CNT_W'(read_index + CNT_W'(1)) == total);
    end
  end

  `MRFE_ASSERT_IMP(a_load_bound, 1'b1, load_count <= total, "load count beyond matrix size")
  `MRFE_ASSERT_IMP(a_read_bound, 1'b1, read_index <= total, "read index beyond matrix size")
  `MRFE_ASSERT_NXT(a_step_pops, cmd.op_step && !cfg_we, op_count == $past(op_count) - OPC_W'(1),
                   "operation step did not pop the stack")
  `MRFE_ASSERT_IMP(a_stack_bound, 1'b1, op_count <= OPC_W'(MAX_OPS), "op stack overfilled")

endmodule

[verif/matrix_rotate_flip_engine_chk.sv]
`timescale 1ns / 1ps
// scoreboard for the matrix rotate and flip engine: tracks the job, predicts and compares results
module matrix_rotate_flip_engine_chk #(
  parameter int MAX_DIM = 8,
  parameter int MAX_OPS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  // element[31:0], op_is_flip[32], zero fill
  input  logic [mrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action[1:0]
  input  logic [mrf_pkg::ACTION_W-1:0]       s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // value[31:0], out_rows[35:32], out_cols[39:36]
  input  logic [mrf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatch_count,
  output int                                 results_waiting,
  output int                                 results_checked
);
  import mrf_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [OUT_DIM_W-1:0] rows;
    logic [OUT_DIM_W-1:0] cols;
    logic                 last;
  } matrix_word_t;

  logic [VALUE_W-1:0] cell_q    [CELLS];
  logic [VALUE_W-1:0] scratch_q [CELLS];
  logic               op_is_flip_q [MAX_OPS];
  int unsigned        row_dim, col_dim, op_depth, load_pos, read_pos;
  logic               swapped;
  matrix_word_t       expected_words [$];

  function automatic int unsigned dim_from_reg(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned cur_rows();
    return swapped ? col_dim : row_dim;
  endfunction

  function automatic int unsigned cur_cols();
    return swapped ? row_dim : col_dim;
  endfunction

  function automatic void clear_job();
    for (int j = 0; j < CELLS; j++) cell_q[j] = '0;
    for (int j = 0; j < MAX_OPS; j++) op_is_flip_q[j] = 1'b0;
    op_depth = 0;
    load_pos = 0;
    read_pos = 0;
    swapped  = 1'b0;
  endfunction

  // vertical flip: row order reversed
  function automatic void flip_rows(int unsigned r, int unsigned c);
    for (int unsigned i = 0; i < r; i++)
      for (int unsigned k = 0; k < c; k++)
        scratch_q[i * c + k] = cell_q[(r - 1 - i) * c + k];
    for (int unsigned j = 0; j < r * c; j++) cell_q[j] = scratch_q[j];
  endfunction

  // counterclockwise quarter turn, r by c becomes c by r
  function automatic void turn_quarter(int unsigned r, int unsigned c);
    for (int unsigned i = 0; i < c; i++)
      for (int unsigned k = 0; k < r; k++)
        scratch_q[i * r + k] = cell_q[k * c + (c - 1 - i)];
    for (int unsigned j = 0; j < r * c; j++) cell_q[j] = scratch_q[j];
    swapped = ~swapped;
  endfunction

  function automatic void model_action(logic [ACTION_W-1:0] act,
                                       logic [ELEMENT_W-1:0] elem, logic flip);
    matrix_word_t word;
    int unsigned  total;
    total = row_dim * col_dim;
    case (act)
      ACT_LOAD: begin
        if (load_pos < total) begin
          cell_q[load_pos] = elem;
          load_pos++;
        end
      end
      ACT_PUSH: begin
        if (op_depth < MAX_OPS) begin
          op_is_flip_q[op_depth] = flip;
          op_depth++;
        end
      end
      ACT_APPLY: begin
        // newest operation first
        while (op_depth > 0) begin
          op_depth--;
          if (op_is_flip_q[op_depth]) flip_rows(cur_rows(), cur_cols());
          else turn_quarter(cur_rows(), cur_cols());
        end
        read_pos   = 0;
        word.value = '0;
        word.rows  = OUT_DIM_W'(cur_rows());
        word.cols  = OUT_DIM_W'(cur_cols());
        word.last  = 1'b0;
        expected_words.push_back(word);
      end
      default: begin
        if (read_pos < total && read_pos < CELLS) begin
          word.value = cell_q[read_pos];
          word.rows  = OUT_DIM_W'(cur_rows());
          word.cols  = OUT_DIM_W'(cur_cols());
          word.last  = (read_pos + 1 == total);
          read_pos++;
          expected_words.push_back(word);
        end
      end
    endcase
  endfunction

  task automatic report_field(input string field, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    matrix_word_t seen, want;
    if (rst) begin
      row_dim = 1;
      col_dim = 1;
      clear_job();
      expected_words.delete();
      mismatch_count  = 0;
      results_checked = 0;
    end else begin
      // outgoing result first: it is older than anything the input side adds now
      if (m_axis_tvalid && m_axis_tready) begin
        seen.value = m_axis_tdata[VALUE_W-1:0];
        seen.rows  = m_axis_tdata[VALUE_W +: OUT_DIM_W];
        seen.cols  = m_axis_tdata[VALUE_W + OUT_DIM_W +: OUT_DIM_W];
        seen.last  = m_axis_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %0h/%0d/%0d/%0b",
                   $time, seen.value, seen.rows, seen.cols, seen.last);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (seen.value !== want.value) report_field("value", want.value, seen.value);
          if (seen.rows !== want.rows) report_field("out_rows", want.rows, seen.rows);
          if (seen.cols !== want.cols) report_field("out_cols", want.cols, seen.cols);
          if (seen.last !== want.last) report_field("last", want.last, seen.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) row_dim = dim_from_reg(cfg_data);
        else col_dim = dim_from_reg(cfg_data);
        clear_job();
      end
      if (s_axis_tvalid && s_axis_tready)
        model_action(s_axis_tuser, s_axis_tdata[ELEMENT_W-1:0], s_axis_tdata[ELEMENT_W]);
    end
    results_waiting = expected_words.size();
  end

endmodule

[verif/matrix_rotate_flip_engine_tb.sv]
`timescale 1ns / 1ps
// testbench top of the matrix rotate and flip engine: clock, reset, stimulus and verdict
module matrix_rotate_flip_engine_tb;
  import mrf_pkg::*;

  localparam int MAX_DIM        = 8;
  localparam int MAX_OPS        = 16;
  localparam int ITEM_TARGET    = 1900;
  // apply worst case: a read and a compose step per stacked op, a divide step per row, plus rebuild and issue
  localparam int SETTLE_CYCLES  = 2 * MAX_OPS + MAX_DIM + 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // element[31:0], op_is_flip[32], zero fill [39:33]
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  // action[1:0]
  logic [ACTION_W-1:0]     s_axis_tuser  = ACT_LOAD;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // value[31:0], out_rows[35:32], out_cols[39:36]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  int mismatch_count, results_waiting, results_checked;
  int burst_left  = 0;
  int items_sent  = 0;
  int jobs_run    = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  matrix_rotate_flip_engine #(
    .MAX_DIM   (MAX_DIM),
    .MAX_OPS   (MAX_OPS),
    .DATA_WIDTH(32)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  matrix_rotate_flip_engine_chk #(
    .MAX_DIM(MAX_DIM),
    .MAX_OPS(MAX_OPS)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_waiting(results_waiting),
    .results_checked(results_checked)
  );

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // size the stimulus needs: a zero register reads as one, anything past the maximum as the maximum
  function automatic int dim_of(logic [CFG_DATA_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return raw;
  endfunction

  // mostly small matrices, now and then the out-of-range codes and the full size
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 15));
    if (roll <= 3) return CFG_DATA_W'($urandom_range(5, MAX_DIM));
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  // extreme words now and then, otherwise any pattern
  function automatic logic [ELEMENT_W-1:0] pick_element();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction and wait for it to be taken; tvalid stays high within a burst
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ELEMENT_W-1:0] elem,
                           input logic flip);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      // a gap before the next burst, so tvalid is never lowered and raised in one step
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_TDATA_W - ELEMENT_W - 1){1'b0}}, flip, elem};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // stop offering, let every expected result come back, then give the block time to go idle
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (results_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; the caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // row-major loads, optionally with pushes mixed in (pushes leave the store alone)
  task automatic load_values(input int count, input bit with_pushes);
    for (int j = 0; j < count; j++) begin
      if (with_pushes && $urandom_range(0, 6) == 0)
        send_item(ACT_PUSH, $urandom, $urandom_range(0, 1));
      send_item(ACT_LOAD, pick_element(), $urandom_range(0, 1));
    end
  endtask

  task automatic push_ops(input int count);
    repeat (count) send_item(ACT_PUSH, $urandom, $urandom_range(0, 1));
  endtask

  // reads with some noise; only called once every cell of the job holds a loaded word
  task automatic read_words(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0)
        send_item(ACTION_W'($urandom_range(0, 3)), pick_element(), $urandom_range(0, 1));
      send_item(ACT_READ, $urandom, $urandom_range(0, 1));
    end
  endtask

  // one job: new sizes, loads, then rounds of operations, apply and read-out
  task automatic run_job();
    logic [CFG_DATA_W-1:0] raw_r, raw_c;
    int total, kind, loaded, n;
    drain_block();
    raw_r = pick_dim();
    raw_c = pick_dim();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_ROW_COUNT, raw_r);
      write_reg(CFG_COL_COUNT, raw_c);
    end else begin
      write_reg(CFG_COL_COUNT, raw_c);
      write_reg(CFG_ROW_COUNT, raw_r);
    end
    cfg_we <= 1'b0;
    jobs_run++;
    total = dim_of(raw_r) * dim_of(raw_c);
    kind  = $urandom_range(0, 9);
    if (kind >= 7) begin
      // apply in the middle of loading
      loaded = $urandom_range(0, total - 1);
      load_values(loaded, 1'b0);
      if (kind == 9) begin
        // any stack, so unloaded cells get moved around: no reads in this job
        push_ops($urandom_range(1, 6));
        send_item(ACT_APPLY, $urandom, $urandom_range(0, 1));
        load_values($urandom_range(0, total - loaded + 1), 1'b0);
        return;
      end
      // a stack that composes to no change keeps the loaded cells a row-major prefix
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          send_item(ACT_PUSH, $urandom, 1'b1);
          send_item(ACT_PUSH, $urandom, 1'b1);
        end
        2: repeat (4) send_item(ACT_PUSH, $urandom, 1'b0);
        default: begin
          send_item(ACT_PUSH, $urandom, 1'b1);
          repeat (4) send_item(ACT_PUSH, $urandom, 1'b0);
          send_item(ACT_PUSH, $urandom, 1'b1);
        end
      endcase
      send_item(ACT_APPLY, $urandom, $urandom_range(0, 1));
      load_values(total - loaded, 1'b0);
    end else begin
      load_values(total, 1'b1);
    end
    // surplus loads are dropped by the block
    load_values($urandom_range(0, 2), 1'b0);
    repeat ($urandom_range(1, 4)) begin
      // deep stacks now and then, near and beyond the stack depth
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_OPS - 1, MAX_OPS + 4)
                                      : $urandom_range(0, 5);
      push_ops(n);
      if ($urandom_range(0, 9) != 0) send_item(ACT_APPLY, $urandom, $urandom_range(0, 1));
      // usually the whole matrix, sometimes a part, sometimes past the end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total + 2)
                                      : total + $urandom_range(0, 1);
      read_words(n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall patterns of its own, with long hold-offs to back the block up
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int segment, mode, span;
    segment = 0;
    while (rst) @(posedge clk);
    forever begin
      segment++;
      if (segment == 8 || $urandom_range(0, 24) == 0) begin
        // long hold-off while the sender keeps offering
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
        for (int j = 0; j < span; j++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= j[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction on either side ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, results_waiting);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: a one-row job, the row register written out of range at the low end
    write_reg(CFG_ROW_COUNT, '0);
    write_reg(CFG_COL_COUNT, 4'd3);
    cfg_we <= 1'b0;
    send_item(ACT_LOAD, 32'h8000_0000, 1'b1);
    send_item(ACT_LOAD, 32'h7fff_ffff, 1'b0);
    send_item(ACT_LOAD, 32'hffff_ffff, 1'b1);
    send_item(ACT_LOAD, 32'h0000_0000, 1'b0);   // surplus, dropped
    send_item(ACT_READ, 32'h0, 1'b0);           // read before any apply
    send_item(ACT_APPLY, 32'h0, 1'b0);          // empty stack, restarts reading
    send_item(ACT_PUSH, 32'h0, 1'b0);           // rotate
    send_item(ACT_PUSH, 32'h0, 1'b1);           // flip, runs first
    send_item(ACT_APPLY, 32'h0, 1'b0);
    repeat (4) send_item(ACT_READ, 32'hffff_ffff, 1'b1);   // last one is past the end

    // directed: apply halfway through loading, then loads into the current layout
    drain_block();
    write_reg(CFG_COL_COUNT, 4'd15);
    write_reg(CFG_ROW_COUNT, 4'd2);
    write_reg(CFG_COL_COUNT, 4'd2);
    cfg_we <= 1'b0;
    send_item(ACT_LOAD, 32'h5555_aaaa, 1'b0);
    send_item(ACT_LOAD, 32'haaaa_5555, 1'b1);
    send_item(ACT_PUSH, 32'h0, 1'b1);
    send_item(ACT_PUSH, 32'h0, 1'b1);
    send_item(ACT_APPLY, 32'h0, 1'b0);
    send_item(ACT_LOAD, 32'h0000_0001, 1'b0);
    send_item(ACT_LOAD, 32'hfffe_ffff, 1'b1);
    repeat (4) send_item(ACT_READ, 32'h0, 1'b0);

    // random jobs
    while (items_sent < ITEM_TARGET) run_job();

    drain_block();
    $display("covered %0d jobs with sizes from 1x1 to %0dx%0d, out-of-range size codes included",
             jobs_run, MAX_DIM, MAX_DIM);
    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[matrix_rotate_flip_engine.f]
+incdir+rtl
rtl/mrf_pkg.sv
rtl/mrf_ctrl.sv
rtl/mrf_datapath.sv
rtl/matrix_rotate_flip_engine.sv
verif/matrix_rotate_flip_engine_chk.sv
verif/matrix_rotate_flip_engine_tb.sv
